// ===== rtl/dl_pkg.sv =====
// Package for the declaration lexer: lexer modes, token kinds, the event record
// and the character class helpers. No dependencies.
package dl_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE      = 4'd0,
      MODE_IDENT     = 4'd1,
      MODE_NUMBER    = 4'd2,
      MODE_COLON     = 4'd3,
      MODE_TYPE_WAIT = 4'd4,
      MODE_PTR_WAIT  = 4'd5,
      MODE_TYPE_NAME = 4'd6,
      MODE_PTR_NAME  = 4'd7,
      MODE_SLASH     = 4'd8,
      MODE_COMMENT   = 4'd9
   } lex_mode_type;

   typedef enum logic [2:0] {
      KIND_IDENT    = 3'd0,
      KIND_TYPE     = 3'd1,
      KIND_PTR      = 3'd2,
      KIND_NUMBER   = 3'd3,
      KIND_ASSIGN   = 3'd4,
      KIND_STMT_END = 3'd5,
      KIND_OTHER    = 3'd6,
      KIND_END      = 3'd7
   } tok_kind_type;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // One token event as it leaves the block.
   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   tok_char;
      logic         has_char;
      logic         first;
      logic         close;
      logic         last;
   } tok_event_type;

   // Events produced by one character, in order.
   typedef struct packed {
      logic [1:0]    count;
      tok_event_type ev0;
      tok_event_type ev1;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic tok_event_type make_event(input tok_kind_type kind,
                                                input logic [7:0] c,
                                                input logic has,
                                                input logic first,
                                                input logic close);
      tok_event_type ev;
      ev.kind     = kind;
      ev.tok_char = has ? c : 8'h00;
      ev.has_char = has;
      ev.first    = first;
      ev.close    = close;
      ev.last     = 1'b0;
      return ev;
   endfunction

endpackage

// ===== rtl/dl_lex_core.sv =====
// Lexer mode register and the per-character event logic.
// Depends on dl_pkg.
module dl_lex_core
   import dl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] in_char,
   input  logic       in_end,
   output push_type   push
);

   lex_mode_type  mode_ff, mode_in;
   tok_event_type pre_ev, idle_ev, second_ev, ev0, ev1;
   logic          pre_v, idle_v, second_v, use_idle;
   lex_mode_type  idle_mode, stay_mode;

   // Handling of a character as seen from the idle mode.
   always_comb begin
      idle_v    = 1'b0;
      idle_mode = MODE_IDLE;
      idle_ev   = make_event(KIND_OTHER, in_char, 1'b1, 1'b1, 1'b1);
      if (is_space(in_char)) begin
         idle_v = 1'b0;
      end else if (in_char == CH_COLON) begin
         idle_mode = MODE_COLON;
      end else if (in_char == CH_SLASH) begin
         idle_mode = MODE_SLASH;
      end else if (in_char == CH_SEMI) begin
         idle_v  = 1'b1;
         idle_ev = make_event(KIND_STMT_END, in_char, 1'b0, 1'b1, 1'b1);
      end else if (is_letter(in_char)) begin
         idle_v    = 1'b1;
         idle_mode = MODE_IDENT;
         idle_ev   = make_event(KIND_IDENT, in_char, 1'b1, 1'b1, 1'b0);
      end else if (is_digit(in_char)) begin
         idle_v    = 1'b1;
         idle_mode = MODE_NUMBER;
         idle_ev   = make_event(KIND_NUMBER, in_char, 1'b1, 1'b1, 1'b0);
      end else begin
         idle_v = 1'b1;
      end
   end

   // Mode-specific event that comes before any idle handling.
   always_comb begin
      pre_v     = 1'b0;
      pre_ev    = make_event(KIND_END, in_char, 1'b0, 1'b1, 1'b1);
      use_idle  = 1'b0;
      stay_mode = mode_ff;
      if (in_end) begin
         stay_mode = MODE_IDLE;
         case (mode_ff)
            MODE_IDENT: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_IDENT, in_char, 1'b0, 1'b0, 1'b1);
            end
            MODE_NUMBER: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_NUMBER, in_char, 1'b0, 1'b0, 1'b1);
            end
            MODE_TYPE_NAME: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_TYPE, in_char, 1'b0, 1'b0, 1'b1);
            end
            MODE_PTR_NAME: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_PTR, in_char, 1'b0, 1'b0, 1'b1);
            end
            MODE_COLON, MODE_TYPE_WAIT: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_TYPE, in_char, 1'b0, 1'b1, 1'b1);
            end
            MODE_PTR_WAIT: begin
               pre_v  = 1'b1;
               pre_ev = make_event(KIND_PTR, in_char, 1'b0, 1'b1, 1'b1);
            end
            default: pre_v = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            MODE_IDENT, MODE_TYPE_NAME, MODE_PTR_NAME, MODE_NUMBER: begin
               pre_v = 1'b1;
               if ((mode_ff == MODE_NUMBER) ? is_digit(in_char)
                                            : (is_letter(in_char) || is_digit(in_char))) begin
                  pre_ev = make_event(
                     (mode_ff == MODE_IDENT)     ? KIND_IDENT :
                     (mode_ff == MODE_NUMBER)    ? KIND_NUMBER :
                     (mode_ff == MODE_TYPE_NAME) ? KIND_TYPE : KIND_PTR,
                     in_char, 1'b1, 1'b0, 1'b0);
               end else begin
                  pre_ev = make_event(
                     (mode_ff == MODE_IDENT)     ? KIND_IDENT :
                     (mode_ff == MODE_NUMBER)    ? KIND_NUMBER :
                     (mode_ff == MODE_TYPE_NAME) ? KIND_TYPE : KIND_PTR,
                     in_char, 1'b0, 1'b0, 1'b1);
                  use_idle = 1'b1;
               end
            end
            MODE_COLON, MODE_TYPE_WAIT: begin
               if (mode_ff == MODE_COLON && in_char == CH_EQUAL) begin
                  pre_v     = 1'b1;
                  pre_ev    = make_event(KIND_ASSIGN, in_char, 1'b0, 1'b1, 1'b1);
                  stay_mode = MODE_IDLE;
               end else if (is_space(in_char)) begin
                  stay_mode = MODE_TYPE_WAIT;
               end else if (in_char == CH_AT) begin
                  stay_mode = MODE_PTR_WAIT;
               end else if (is_letter(in_char)) begin
                  pre_v     = 1'b1;
                  pre_ev    = make_event(KIND_TYPE, in_char, 1'b1, 1'b1, 1'b0);
                  stay_mode = MODE_TYPE_NAME;
               end else begin
                  // empty type name, then treat the character as fresh input
                  pre_v    = 1'b1;
                  pre_ev   = make_event(KIND_TYPE, in_char, 1'b0, 1'b1, 1'b1);
                  use_idle = 1'b1;
               end
            end
            MODE_PTR_WAIT: begin
               pre_v = 1'b1;
               if (is_letter(in_char)) begin
                  pre_ev    = make_event(KIND_PTR, in_char, 1'b1, 1'b1, 1'b0);
                  stay_mode = MODE_PTR_NAME;
               end else begin
                  pre_ev   = make_event(KIND_PTR, in_char, 1'b0, 1'b1, 1'b1);
                  use_idle = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (in_char == CH_SLASH) begin
                  stay_mode = MODE_COMMENT;
               end else begin
                  use_idle = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_char == CH_CR || in_char == CH_LF) begin
                  stay_mode = MODE_IDLE;
               end
            end
            default: use_idle = 1'b1;
         endcase
      end
   end

   // Merge the two phases into an ordered pair and mark the last event.
   always_comb begin
      second_v  = in_end || (use_idle && idle_v);
      second_ev = in_end ? make_event(KIND_END, in_char, 1'b0, 1'b1, 1'b1) : idle_ev;
      mode_in   = use_idle ? idle_mode : stay_mode;
      ev0       = pre_v ? pre_ev : second_ev;
      ev1       = second_ev;
      push.count = {1'b0, pre_v} + {1'b0, second_v};
      if (pre_v && second_v) begin
         ev1.last = 1'b1;
      end else begin
         ev0.last = 1'b1;
      end
      push.ev0 = ev0;
      push.ev1 = ev1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== rtl/dl_result_fifo.sv =====
// Two-entry result queue that takes up to two events per cycle.
// Depends on dl_pkg.
module dl_result_fifo
   import dl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  push_type      push,
   input  logic          pop,
   output tok_event_type head,
   output logic          head_valid,
   output logic [1:0]    space
);

   tok_event_type e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]    cnt_ff, cnt_in, base;

   assign head       = e0_ff;
   assign head_valid = (cnt_ff != 2'd0);
   assign space      = 2'd2 - cnt_ff + {1'b0, pop};
   assign base       = cnt_ff - {1'b0, pop};

   always_comb begin
      e0_in  = pop ? e1_ff : e0_ff;
      e1_in  = e1_ff;
      cnt_in = base + push.count;
      if (push.count != 2'd0) begin
         case (base)
            2'd0: begin
               e0_in = push.ev0;
               e1_in = push.ev1;
            end
            2'd1: e1_in = push.ev0;
            default: e1_in = e1_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

// ===== rtl/declaration_lexer.sv =====
// Top level of the declaration lexer: input register, lexer core, result queue.
// Depends on dl_pkg, dl_lex_core and dl_result_fifo.
//
// Streaming lexer for simple declarations such as "x : int := 1;". Each
// request transaction carries one character, or an end-of-text mark in
// req_tuser, and yields zero, one or two token events on the response side.
// Identifiers, numbers and type names stream out one character per event and
// end with a close event; ':=' gives an assignment token, ';' a statement end,
// '//' comments run to CR or LF and spaces are skipped. rsp_tlast marks the
// last event caused by a request. A request passes the input register and the
// queue register before its first response. A new character is taken every
// cycle while each one gives at most one event and rsp_tready stays high; a
// character that gives two events (an open token or a pending type closed by
// a character that makes its own event, or end of text with a token or type
// pending) may stall input while one response port drains the two-entry queue.
module declaration_lexer
   import dl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tuser,   // [0] in_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tok_char
   output logic [5:0] rsp_tuser,   // [2:0] tok_kind, [3] has_char, [4] tok_first, [5] tok_close
   output logic       rsp_tlast    // run_last
);

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_char_ff;
   logic          s1_end_ff;
   logic          advance, pop, head_valid;
   logic [1:0]    space;
   push_type      push_raw, push_gated;
   tok_event_type head;

   // Advance the held character once the queue can absorb all of its events.
   assign advance    = s1_valid_ff && (push_raw.count <= space);
   assign req_tready = !s1_valid_ff || advance;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      push_gated = push_raw;
      if (!advance) begin
         push_gated.count = 2'd0;
      end
   end

   assign s1_valid_in = req_tvalid || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      // hold the character until it advances
      if (req_tready) begin
         s1_char_ff <= req_tdata;
         s1_end_ff  <= req_tuser;
      end
   end

   dl_lex_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_char (s1_char_ff),
      .in_end  (s1_end_ff),
      .push    (push_raw)
   );

   dl_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_gated),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .space      (space)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head.tok_char;
   assign rsp_tuser  = {head.close, head.first, head.has_char, head.kind};
   assign rsp_tlast  = head.last;

endmodule

// ===== tb/declaration_lexer_tb.sv =====
// Self-checking testbench for declaration_lexer: a directed table, then random declaration
// text and noise, checked event by event against a local model of the lexer modes.
// Depends on dl_pkg for the mode and token kind enums, the event record and character codes.
module declaration_lexer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dl_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned RANDOM_ITEMS  = 520;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam tok_event_type NO_EVENT    = '0;

   // One row of stimulus. When typed is set, count/ev0/ev1 hold the events expected for
   // this character and replace the model's prediction; the model still tracks the mode.
   typedef struct packed {
      logic [7:0]    ch;
      logic          is_end;
      logic          typed;
      logic [1:0]    count;
      tok_event_type ev0;
      tok_event_type ev1;
   } stim_row_type;

   // Directed walk through every mode but the type name mode: identifier closed by a space,
   // pointer type closed by ';', number closed by ':', assignment, lone slash, comment to LF,
   // other characters at both ends of the byte range, end of text with a pending '@', empty
   // type before a digit and before 8'hFF, and end of text right after a slash.
   localparam int unsigned DIRECTED_COUNT = 27;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{"x",   1'b0, 1'b1, 2'd1, '{KIND_IDENT, "x", 1'b1, 1'b1, 1'b0, 1'b1}, NO_EVENT},
      '{"9",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{" ",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{":",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{" ",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"@",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"i",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{";",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"7",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{":",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"=",   1'b0, 1'b1, 2'd1, '{KIND_ASSIGN, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}, NO_EVENT},
      '{"/",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{" ",   1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
      '{"/",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"/",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{8'hFF, 1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
      '{CH_LF, 1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
      '{8'h00, 1'b0, 1'b1, 2'd1, '{KIND_OTHER, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1}, NO_EVENT},
      '{":",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"@",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{8'hFF, 1'b1, 1'b1, 2'd2, '{KIND_PTR, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
                                 '{KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{":",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{"5",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{":",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{8'hFF, 1'b0, 1'b1, 2'd2, '{KIND_TYPE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
                                 '{KIND_OTHER, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{"/",   1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
      '{8'h00, 1'b1, 1'b1, 2'd1, '{KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}, NO_EVENT}
   };

   localparam logic [7:0] PUNCT_CHARS [8] = '{CH_COLON, CH_EQUAL, CH_SLASH, CH_SEMI,
                                              CH_AT, CH_CR, CH_LF, 8'h20};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_char
   logic       req_tuser = 1'b0;    // [0] in_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] tok_char
   logic [5:0] rsp_tuser;           // [2:0] tok_kind, [3] has_char, [4] tok_first, [5] tok_close
   logic       rsp_tlast;           // run_last

   declaration_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model state, the events of the character being predicted, and the token events
   // still owed by the block in arrival order.
   lex_mode_type  lexer_mode = MODE_IDLE;
   tok_event_type char_events[$];
   tok_event_type pending_tokens[$];
   stim_row_type  stimulus[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned chars_sent = 0;
   int unsigned double_event_chars = 0;
   int unsigned events_checked = 0;
   int unsigned kind_seen [8] = '{default: 0};

   // ---------------------------------------------------------------------------------
   // Lexer model
   // ---------------------------------------------------------------------------------
   function automatic logic letter_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic blank_char(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic void add_event(tok_kind_type kind, logic [7:0] c, logic has,
                                     logic first, logic close);
      tok_event_type ev;
      ev.kind     = kind;
      ev.tok_char = has ? c : 8'h00;
      ev.has_char = has;
      ev.first    = first;
      ev.close    = close;
      ev.last     = 1'b0;
      char_events = {char_events, ev};
   endfunction

   // A character seen with no token open.
   function automatic void lex_from_idle(logic [7:0] c);
      lexer_mode = MODE_IDLE;
      if (blank_char(c)) begin
         return;
      end else if (c == CH_COLON) begin
         lexer_mode = MODE_COLON;
      end else if (c == CH_SLASH) begin
         lexer_mode = MODE_SLASH;
      end else if (c == CH_SEMI) begin
         add_event(KIND_STMT_END, 8'h00, 1'b0, 1'b1, 1'b1);
      end else if (letter_char(c)) begin
         add_event(KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
         lexer_mode = MODE_IDENT;
      end else if (digit_char(c)) begin
         add_event(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
         lexer_mode = MODE_NUMBER;
      end else begin
         add_event(KIND_OTHER, c, 1'b1, 1'b1, 1'b1);
      end
   endfunction

   // Streamed token: extend it, or close it and restart from idle with the same character.
   function automatic void lex_stream(logic [7:0] c, tok_kind_type kind, logic keep);
      if (keep) begin
         add_event(kind, c, 1'b1, 1'b0, 1'b0);
      end else begin
         add_event(kind, 8'h00, 1'b0, 1'b0, 1'b1);
         lex_from_idle(c);
      end
   endfunction

   function automatic void lex_type_wait(logic [7:0] c);
      if (blank_char(c)) begin
         lexer_mode = MODE_TYPE_WAIT;
      end else if (c == CH_AT) begin
         lexer_mode = MODE_PTR_WAIT;
      end else if (letter_char(c)) begin
         add_event(KIND_TYPE, c, 1'b1, 1'b1, 1'b0);
         lexer_mode = MODE_TYPE_NAME;
      end else begin
         add_event(KIND_TYPE, 8'h00, 1'b0, 1'b1, 1'b1);
         lex_from_idle(c);
      end
   endfunction

   // Fill char_events with what one accepted transaction produces and advance the mode.
   function automatic void predict_tokens(logic [7:0] c, logic is_end);
      tok_event_type tail;
      char_events.delete();
      if (is_end) begin
         case (lexer_mode)
            MODE_IDENT:     add_event(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_NUMBER:    add_event(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_TYPE_NAME: add_event(KIND_TYPE, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_PTR_NAME:  add_event(KIND_PTR, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_COLON, MODE_TYPE_WAIT: add_event(KIND_TYPE, 8'h00, 1'b0, 1'b1, 1'b1);
            MODE_PTR_WAIT:  add_event(KIND_PTR, 8'h00, 1'b0, 1'b1, 1'b1);
            default: ;
         endcase
         add_event(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
         lexer_mode = MODE_IDLE;
      end else begin
         case (lexer_mode)
            MODE_IDENT:     lex_stream(c, KIND_IDENT, letter_char(c) || digit_char(c));
            MODE_NUMBER:    lex_stream(c, KIND_NUMBER, digit_char(c));
            MODE_TYPE_NAME: lex_stream(c, KIND_TYPE, letter_char(c) || digit_char(c));
            MODE_PTR_NAME:  lex_stream(c, KIND_PTR, letter_char(c) || digit_char(c));
            MODE_COLON: begin
               if (c == CH_EQUAL) begin
                  add_event(KIND_ASSIGN, 8'h00, 1'b0, 1'b1, 1'b1);
                  lexer_mode = MODE_IDLE;
               end else begin
                  lex_type_wait(c);
               end
            end
            MODE_TYPE_WAIT: lex_type_wait(c);
            MODE_PTR_WAIT: begin
               // no space skipping after '@'
               if (letter_char(c)) begin
                  add_event(KIND_PTR, c, 1'b1, 1'b1, 1'b0);
                  lexer_mode = MODE_PTR_NAME;
               end else begin
                  add_event(KIND_PTR, 8'h00, 1'b0, 1'b1, 1'b1);
                  lex_from_idle(c);
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) lexer_mode = MODE_COMMENT;
               else lex_from_idle(c);
            end
            MODE_COMMENT: begin
               if (c == CH_CR || c == CH_LF) lexer_mode = MODE_IDLE;
            end
            default: lex_from_idle(c);
         endcase
      end
      if (char_events.size() > 0) begin
         tail = char_events.pop_back();
         tail.last = 1'b1;
         char_events = {char_events, tail};
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Random text
   // ---------------------------------------------------------------------------------
   function automatic void queue_char(logic [7:0] c, logic is_end);
      stim_row_type row;
      row        = '0;
      row.ch     = c;
      row.is_end = is_end;
      stimulus   = {stimulus, row};
   endfunction

   function automatic logic [7:0] pick_blank();
      return ($urandom_range(0, 3) == 0) ? 8'(9 + $urandom_range(0, 4)) : 8'h20;
   endfunction

   function automatic logic [7:0] pick_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
   endfunction

   function automatic logic [7:0] pick_alnum();
      int unsigned r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'("0" + r);
      return pick_letter();
   endfunction

   // Mostly well-formed "name : [@]type [:= value];" lines with an occasional comment,
   // some cut short; the rest is raw bytes and loose punctuation. End marks are sprinkled in.
   function automatic void append_declaration();
      logic [7:0]  text[$];
      logic [7:0]  b;
      int unsigned roll;
      int unsigned keep;
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
         repeat ($urandom_range(0, 1)) text = {text, pick_blank()};
         text = {text, pick_letter()};
         repeat ($urandom_range(0, 5)) text = {text, pick_alnum()};
         repeat ($urandom_range(0, 2)) text = {text, pick_blank()};
         text = {text, CH_COLON};
         repeat ($urandom_range(0, 2)) text = {text, pick_blank()};
         if ($urandom_range(0, 2) == 0) text = {text, CH_AT};
         if ($urandom_range(0, 9) != 0) begin
            text = {text, pick_letter()};
            repeat ($urandom_range(0, 4)) text = {text, pick_alnum()};
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 1)) text = {text, pick_blank()};
            text = {text, CH_COLON};
            text = {text, CH_EQUAL};
            repeat ($urandom_range(0, 1)) text = {text, pick_blank()};
            if ($urandom_range(0, 3) == 0) begin
               text = {text, pick_letter()};
            end else begin
               repeat ($urandom_range(1, 4)) text = {text, 8'("0" + $urandom_range(0, 9))};
            end
         end
         text = {text, CH_SEMI};
         if ($urandom_range(0, 4) == 0) begin
            text = {text, CH_SLASH};
            text = {text, CH_SLASH};
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               text = {text, ((b == CH_CR || b == CH_LF) ? 8'h2A : b)};
            end
            text = {text, ($urandom_range(0, 1) ? CH_CR : CH_LF)};
         end else begin
            text = {text, CH_LF};
         end
         // cut a line short now and then
         keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, text.size()) : text.size();
      end else if (roll < 90) begin
         repeat ($urandom_range(1, 6)) text = {text, 8'($urandom_range(0, 255))};
         keep = text.size();
      end else begin
         repeat ($urandom_range(1, 4)) text = {text, PUNCT_CHARS[$urandom_range(0, 7)]};
         keep = text.size();
      end
      for (int unsigned i = 0; i < keep; i++) queue_char(text[i], 1'b0);
      if (roll >= 95 || $urandom_range(0, 9) == 0) queue_char(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // ---------------------------------------------------------------------------------
   // Response side: random back-pressure at the falling edge, checking at the rising edge.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic string event_text(tok_event_type e);
      return $sformatf("kind=%0d char=%02h has=%b first=%b close=%b last=%b",
                       e.kind, e.tok_char, e.has_char, e.first, e.close, e.last);
   endfunction

   always @(posedge clock) begin
      tok_event_type got;
      tok_event_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.kind     = tok_kind_type'(rsp_tuser[2:0]);
         got.tok_char = rsp_tdata;
         got.has_char = rsp_tuser[3];
         got.first    = rsp_tuser[4];
         got.close    = rsp_tuser[5];
         got.last     = rsp_tlast;
         if (pending_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] unexpected token event: %s", $realtime, event_text(got));
         end else begin
            want = pending_tokens.pop_front();
            events_checked++;
            kind_seen[want.kind]++;
            if (got.kind !== want.kind || got.tok_char !== want.tok_char ||
                got.has_char !== want.has_char || got.first !== want.first ||
                got.close !== want.close || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("[%0t] token mismatch\n  expected %s\n  actual   %s",
                           $realtime, event_text(want), event_text(got));
            end
         end
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d token events still owed",
                  cycle_count, pending_tokens.size());
         $display("declaration_lexer_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Request side: reset, then the directed table and the random text in three idle phases.
   // ---------------------------------------------------------------------------------
   initial begin
      stim_row_type row;
      int unsigned  total;
      for (int unsigned i = 0; i < DIRECTED_COUNT; i++) stimulus = {stimulus, DIRECTED_ROWS[i]};
      while (stimulus.size() < DIRECTED_COUNT + RANDOM_ITEMS) append_declaration();
      total = stimulus.size();

      // hold reset at the start, release on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int unsigned idx = 0; idx < total; idx++) begin
         row = stimulus[idx];
         // sender idles lightly while the receiver stalls hard, then the reverse,
         // then both run flat out
         if (idx < total / 3) begin
            send_idle_pct = 15;
            recv_idle_pct = 52;
         end else if (idx < 2 * total / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= row.ch;
         req_tuser  <= row.is_end;
         do @(posedge clock); while (req_tready !== 1'b1);

         // transaction accepted: advance the model; typed rows supply their own events
         predict_tokens(row.ch, row.is_end);
         if (row.typed) begin
            char_events.delete();
            if (row.count > 0) char_events = {char_events, row.ev0};
            if (row.count > 1) char_events = {char_events, row.ev1};
         end
         if (char_events.size() == 2) double_event_chars++;
         foreach (char_events[k]) pending_tokens = {pending_tokens, char_events[k]};
         chars_sent++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain what is owed, then give stray events time to show up
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input transactions (%0d directed, %0d giving two events)",
               chars_sent, DIRECTED_COUNT, double_event_chars);
      $display("checked %0d token events; per kind ident..end: %0d %0d %0d %0d %0d %0d %0d %0d",
               events_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
      if (mismatch_count == 0 && pending_tokens.size() == 0) begin
         $display("declaration_lexer_tb passed");
      end else begin
         $display("%0d mismatches, %0d events never arrived", mismatch_count,
                  pending_tokens.size());
         $display("declaration_lexer_tb failed");
      end
      $finish;
   end

endmodule
